// ----- hdl/drc_pkg.sv -----
// Shared definitions for the dynamic range compressor gain block.
// Holds default widths, envelope phase codes, register indexes and reset values.
// Used by drc_env and dynamic_range_compressor_gain; depends on nothing else.
package drc_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 24;
  localparam int TICK_BITS_DEF      = 16;

  // Envelope phase codes, as reported on the result channel.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ATTACK  = 2'd1;
  localparam logic [1:0] PH_HOLD    = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Configuration register indexes.
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FLOOR        = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ATTACK_TICKS = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_TICKS   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_REL_TICKS    = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ATTACK_STEP  = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_REL_STEP     = 3'd6;

  // Register reset values; each is truncated to its register's width.
  localparam longint RST_THRESHOLD    = 16384;
  localparam longint RST_FLOOR        = 8388608;
  localparam longint RST_ATTACK_TICKS = 100;
  localparam longint RST_HOLD_TICKS   = 1000;
  localparam longint RST_REL_TICKS    = 1000;
  localparam longint RST_ATTACK_STEP  = 83886;
  localparam longint RST_REL_STEP     = 8388;

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    m = (m > c) ? m : c;
    return m;
  endfunction

endpackage

// ----- hdl/drc_env.sv -----
// Envelope follower of the compressor: gain, phase and tick count state
// together with the per-sample update. Depends on drc_pkg.
module drc_env #(
  parameter int SAMPLE_BITS    = drc_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = drc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int TICK_BITS      = drc_pkg::TICK_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-2:0]      level_threshold,
  input  logic [GAIN_FRAC_BITS:0]     gain_floor,
  input  logic [TICK_BITS-1:0]        attack_ticks,
  input  logic [TICK_BITS-1:0]        hold_ticks,
  input  logic [TICK_BITS-1:0]        release_ticks,
  input  logic [GAIN_FRAC_BITS:0]     attack_step,
  input  logic [GAIN_FRAC_BITS:0]     release_step,
  output logic [GAIN_FRAC_BITS:0]     gain_nxt,
  output logic [1:0]                  phase_nxt
);
  import drc_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam logic [GW-1:0] ONE = GW'(1) << GAIN_FRAC_BITS;

  logic [GW-1:0]          gain_r;
  logic [1:0]             phase_r;
  logic [TICK_BITS-1:0]   tick_r;
  logic [TICK_BITS-1:0]   tick_nxt;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] thr;
  logic [GW-1:0]          fl;
  logic                   loud;
  logic                   quiet;

  // The most negative sample maps to 2^(SAMPLE_BITS-1), above any threshold.
  assign mag   = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign thr   = {1'b0, level_threshold};
  assign loud  = mag > thr;
  assign quiet = mag < thr;
  assign fl    = (gain_floor > ONE) ? ONE : gain_floor;

  always_comb begin
    gain_nxt  = gain_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    if (loud) begin
      if (gain_r >= fl && (phase_r == PH_IDLE || phase_r == PH_RELEASE)) begin
        phase_nxt = PH_ATTACK;
        tick_nxt  = attack_ticks;
      end
      if (phase_nxt == PH_HOLD) begin
        tick_nxt = hold_ticks;
      end
    end
    if (quiet && gain_r <= ONE) begin
      if (tick_nxt == '0 && phase_nxt == PH_HOLD) begin
        phase_nxt = PH_RELEASE;
        tick_nxt  = release_ticks;
      end
    end
    case (phase_nxt)
      PH_ATTACK: begin
        if (tick_nxt != '0 && gain_r > fl) begin
          gain_nxt = ((gain_r - fl) > attack_step) ? (gain_r - attack_step) : fl;
          tick_nxt = tick_nxt - 1'b1;
        end else begin
          phase_nxt = PH_HOLD;
          tick_nxt  = hold_ticks;
        end
      end
      PH_HOLD: begin
        if (tick_nxt != '0) begin
          tick_nxt = tick_nxt - 1'b1;
        end else begin
          phase_nxt = PH_RELEASE;
          tick_nxt  = release_ticks;
        end
      end
      PH_RELEASE: begin
        if (tick_nxt != '0 && gain_r < ONE) begin
          tick_nxt = tick_nxt - 1'b1;
          gain_nxt = ((ONE - gain_r) > release_step) ? (gain_r + release_step) : ONE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (gain_r < ONE) begin
          gain_nxt = ONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= ONE;
      phase_r <= PH_IDLE;
      tick_r  <= '0;
    end else if (en) begin
      gain_r  <= gain_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
    end
  end

endmodule

// ----- hdl/dynamic_range_compressor_gain.sv -----
// Dynamic range compressor gain stage: each input transfer carries one signed
// sample, and each output transfer returns it scaled by the envelope gain, with
// the envelope phase. Depends on drc_pkg and drc_env.
//
// One sample is taken every cycle while the result side keeps up. A sample
// passes three registers: the input register, the envelope register (gain and
// phase after the update by drc_env), and the result register fed by the one
// sample-by-gain multiplier. The whole pipeline advances together whenever the
// result register is empty or being drained. Configuration writes take effect
// on the next cycle and should only be made while no sample is in flight.
module dynamic_range_compressor_gain #(
  parameter int SAMPLE_BITS    = drc_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = drc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int TICK_BITS      = drc_pkg::TICK_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 2 + 7) / 8) * 8,
  localparam int CFG_W = drc_pkg::max3(SAMPLE_BITS - 1, GAIN_FRAC_BITS + 1, TICK_BITS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_W-1:0]                    in_tdata,   // sample_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OUT_W-1:0]                   out_tdata,  // sample_out, phase
  input  logic                               cfg_we,
  input  logic [drc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]                   cfg_wdata
);
  import drc_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int TW = TICK_BITS;

  logic [S-2:0]  thr_r;
  logic [GW-1:0] floor_r;
  logic [TW-1:0] atk_ticks_r;
  logic [TW-1:0] hold_ticks_r;
  logic [TW-1:0] rel_ticks_r;
  logic [GW-1:0] atk_step_r;
  logic [GW-1:0] rel_step_r;

  logic                 adv;
  logic                 s1_valid_r;
  logic signed [S-1:0]  s1_sample_r;
  logic                 s2_valid_r;
  logic signed [S-1:0]  s2_sample_r;
  logic [GW-1:0]        s2_gain_r;
  logic [1:0]           s2_phase_r;
  logic                 out_valid_r;
  logic [S-1:0]         out_sample_r;
  logic [1:0]           out_phase_r;
  logic [GW-1:0]        env_gain;
  logic [1:0]           env_phase;
  logic signed [S+GW:0] prod;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= (S-1)'(RST_THRESHOLD);
      floor_r      <= GW'(RST_FLOOR);
      atk_ticks_r  <= TW'(RST_ATTACK_TICKS);
      hold_ticks_r <= TW'(RST_HOLD_TICKS);
      rel_ticks_r  <= TW'(RST_REL_TICKS);
      atk_step_r   <= GW'(RST_ATTACK_STEP);
      rel_step_r   <= GW'(RST_REL_STEP);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD:    thr_r        <= cfg_wdata[S-2:0];
        REG_FLOOR:        floor_r      <= cfg_wdata[GW-1:0];
        REG_ATTACK_TICKS: atk_ticks_r  <= cfg_wdata[TW-1:0];
        REG_HOLD_TICKS:   hold_ticks_r <= cfg_wdata[TW-1:0];
        REG_REL_TICKS:    rel_ticks_r  <= cfg_wdata[TW-1:0];
        REG_ATTACK_STEP:  atk_step_r   <= cfg_wdata[GW-1:0];
        REG_REL_STEP:     rel_step_r   <= cfg_wdata[GW-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  drc_env #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .TICK_BITS      (TICK_BITS)
  ) u_env (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (adv && s1_valid_r),
    .sample          (s1_sample_r),
    .level_threshold (thr_r),
    .gain_floor      (floor_r),
    .attack_ticks    (atk_ticks_r),
    .hold_ticks      (hold_ticks_r),
    .release_ticks   (rel_ticks_r),
    .attack_step     (atk_step_r),
    .release_step    (rel_step_r),
    .gain_nxt        (env_gain),
    .phase_nxt       (env_phase)
  );

  // A signed product shifted right rounds toward minus infinity; with the gain
  // at most 1.0 the result always fits the sample width.
  assign prod = s2_sample_r * $signed({1'b0, s2_gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample_r  <= in_tdata[S-1:0];
      s2_sample_r  <= s1_sample_r;
      s2_gain_r    <= env_gain;
      s2_phase_r   <= env_phase;
      out_sample_r <= prod[GAIN_FRAC_BITS+S-1:GAIN_FRAC_BITS];
      out_phase_r  <= s2_phase_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_phase_r, out_sample_r});

endmodule
